### rtl/glcc_pkg.sv
// Package for the grid line crossing counter: register indexes, band codes,
// the classified-item type passed from front to back, and fixed constants.
// No dependencies.
package glcc_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 12;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HORIZONTAL_CENTER = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTICAL_CENTER   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_BAND        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTER_BAND        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_TOLERANCE   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MISS_LIMIT        = 3'd5;

  // Register reset values.
  localparam logic [9:0]  RST_HORIZONTAL_CENTER = 10'd240;
  localparam logic [9:0]  RST_VERTICAL_CENTER   = 10'd160;
  localparam logic [7:0]  RST_INNER_BAND        = 8'd5;
  localparam logic [7:0]  RST_OUTER_BAND        = 8'd15;
  localparam logic [11:0] RST_ANGLE_TOLERANCE   = 12'd819;
  localparam logic [7:0]  RST_MISS_LIMIT        = 8'd10;

  // Pi/2 in 1/4096 radian units.
  localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

  // Band mask bits.
  localparam logic [2:0] MASK_LEFT   = 3'b100;
  localparam logic [2:0] MASK_MIDDLE = 3'b010;
  localparam logic [2:0] MASK_RIGHT  = 3'b001;
  localparam logic [2:0] MASK_ALL    = 3'b111;

  localparam int unsigned MISS_BITS = 16;
  localparam int unsigned OUT_COUNT_BITS = 16;

  // Input operation codes.
  localparam logic OP_LINE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_LR   = 2'd1,
    AXIS_UD   = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    BAND_MISS   = 2'd0,
    BAND_LEFT   = 2'd1,
    BAND_MIDDLE = 2'd2,
    BAND_RIGHT  = 2'd3
  } band_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic  eof;
    axis_t axis;
    band_t band;
  } item_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [9:0]  horizontal_center;
    logic [9:0]  vertical_center;
    logic [7:0]  inner_band;
    logic [7:0]  outer_band;
    logic [11:0] angle_tolerance;
    logic [7:0]  miss_limit;
  } cfg_t;

endpackage

### rtl/glcc_front.sv
// Front end: takes input transfers, classifies each line by axis and band,
// and pushes the classified item into the queue. Depends on glcc_pkg.
module glcc_front (
  input  glcc_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic signed [14:0]  in_rho,
  input  logic signed [14:0]  in_theta,
  input  logic                q_full,
  output logic                push_valid,
  output glcc_pkg::item_t     push_item
);
  import glcc_pkg::*;

  logic signed [16:0] theta_w;
  logic signed [16:0] theta_up;
  logic signed [16:0] theta_dn;
  logic signed [16:0] tol_w;
  logic signed [16:0] abs_t;
  logic signed [16:0] abs_up;
  logic signed [16:0] abs_dn;
  logic               near_vert;
  logic               near_horz;
  logic [9:0]         center;
  logic signed [16:0] offset_w;
  logic signed [16:0] in_w;
  logic signed [16:0] out_w;
  axis_t              axis;
  band_t              band;

  // The queue decides whether a transfer can happen this cycle.
  assign in_ready   = !q_full;
  assign push_valid = in_valid && !q_full;

  // Angle classification against zero and plus or minus pi/2.
  always_comb begin
    theta_w  = 17'(in_theta);
    theta_up = theta_w - HALF_PI_Q12;
    theta_dn = theta_w + HALF_PI_Q12;
    tol_w    = $signed({5'd0, cfg.angle_tolerance});
    abs_t    = theta_w[16] ? -theta_w : theta_w;
    abs_up   = theta_up[16] ? -theta_up : theta_up;
    abs_dn   = theta_dn[16] ? -theta_dn : theta_dn;
    near_vert = abs_t < tol_w;
    near_horz = (abs_up < tol_w) || (abs_dn < tol_w);
    if (near_vert) begin
      axis = AXIS_LR;
    end else if (near_horz) begin
      axis = AXIS_UD;
    end else begin
      axis = AXIS_NONE;
    end
  end

  // Band classification of the offset from the chosen axis center.
  always_comb begin
    center   = (axis == AXIS_UD) ? cfg.vertical_center : cfg.horizontal_center;
    offset_w = 17'(in_rho) - $signed({3'd0, center, 4'd0});
    in_w     = $signed({5'd0, cfg.inner_band, 4'd0});
    out_w    = $signed({5'd0, cfg.outer_band, 4'd0});
    if ((offset_w > -out_w) && (offset_w < -in_w)) begin
      band = BAND_LEFT;
    end else if ((offset_w > -in_w) && (offset_w < in_w)) begin
      band = BAND_MIDDLE;
    end else if ((offset_w > in_w) && (offset_w < out_w)) begin
      band = BAND_RIGHT;
    end else begin
      band = BAND_MISS;
    end
  end

  // An end-of-frame marker carries no axis.
  always_comb begin
    push_item.eof  = (in_operation == OP_EOF);
    push_item.axis = (in_operation == OP_EOF) ? AXIS_NONE : axis;
    push_item.band = band;
  end

endmodule

### rtl/glcc_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on glcc_pkg.
module glcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  glcc_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output glcc_pkg::item_t pop_item,
  input  logic            pop_ready
);
  import glcc_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/glcc_back.sv
// Back end: applies classified items to the per-axis masks, miss counters
// and net counts, and holds the result in an output register. Depends on glcc_pkg.
module glcc_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         miss_limit,
  input  logic               pop_valid,
  input  glcc_pkg::item_t    pop_item,
  output logic               pop_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_left_right_count,
  output logic signed [15:0] out_up_down_count,
  output logic [2:0]         out_left_right_bands,
  output logic [2:0]         out_up_down_bands
);
  import glcc_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [MISS_BITS-1:0]         MISS_MAX  = {MISS_BITS{1'b1}};

  // Index 0 is the left-right axis, index 1 the up-down axis.
  logic [2:0]                    mask_r    [2];
  logic [2:0]                    mask_nxt  [2];
  logic [MISS_BITS-1:0]          miss_r    [2];
  logic [MISS_BITS-1:0]          miss_nxt  [2];
  logic signed [COUNT_BITS-1:0]  count_r   [2];
  logic signed [COUNT_BITS-1:0]  count_nxt [2];
  logic [2:0]                    merged    [2];
  logic                          hit       [2];
  logic                          out_valid_r;
  logic signed [15:0]            lr_count_r;
  logic signed [15:0]            ud_count_r;
  logic [2:0]                    lr_bands_r;
  logic [2:0]                    ud_bands_r;
  logic signed [15:0]            count16   [2];
  logic                          step;

  // The output register frees up when empty or when its transfer completes.
  assign pop_ready = !out_valid_r || out_ready;
  assign step      = pop_valid && pop_ready;

  // Per-axis state update for one item.
  always_comb begin
    hit[0] = (pop_item.axis == AXIS_LR);
    hit[1] = (pop_item.axis == AXIS_UD);
    for (int i = 0; i < 2; i++) begin
      mask_nxt[i]  = mask_r[i];
      miss_nxt[i]  = miss_r[i];
      count_nxt[i] = count_r[i];
      merged[i]    = 3'b000;
      if (pop_item.eof) begin
        if (miss_r[i] == {{(MISS_BITS-8){1'b0}}, miss_limit}) begin
          mask_nxt[i] = 3'b000;
        end
      end else if (hit[i]) begin
        case (pop_item.band)
          BAND_LEFT: begin
            miss_nxt[i] = '0;
            merged[i]   = mask_r[i] | MASK_LEFT;
            if (merged[i] == MASK_ALL) begin
              mask_nxt[i] = MASK_LEFT;
              if (count_r[i] != COUNT_MAX) begin
                count_nxt[i] = count_r[i] + COUNT_BITS'(1);
              end
            end else begin
              mask_nxt[i] = merged[i];
            end
          end
          BAND_MIDDLE: begin
            miss_nxt[i] = '0;
            mask_nxt[i] = mask_r[i] | MASK_MIDDLE;
          end
          BAND_RIGHT: begin
            miss_nxt[i] = '0;
            merged[i]   = mask_r[i] | MASK_RIGHT;
            if (merged[i] == MASK_ALL) begin
              mask_nxt[i] = MASK_RIGHT;
              if (count_r[i] != COUNT_MIN) begin
                count_nxt[i] = count_r[i] - COUNT_BITS'(1);
              end
            end else begin
              mask_nxt[i] = merged[i];
            end
          end
          default: begin
            if (miss_r[i] != MISS_MAX) begin
              miss_nxt[i] = miss_r[i] + MISS_BITS'(1);
            end
          end
        endcase
      end
    end
  end

  // The result field shows the low 16 bits of the count, sign-extended if narrower.
  generate
    if (COUNT_BITS >= OUT_COUNT_BITS) begin : g_trunc
      assign count16[0] = count_nxt[0][OUT_COUNT_BITS-1:0];
      assign count16[1] = count_nxt[1][OUT_COUNT_BITS-1:0];
    end else begin : g_extend
      assign count16[0] = {{(OUT_COUNT_BITS-COUNT_BITS){count_nxt[0][COUNT_BITS-1]}},
                           count_nxt[0]};
      assign count16[1] = {{(OUT_COUNT_BITS-COUNT_BITS){count_nxt[1][COUNT_BITS-1]}},
                           count_nxt[1]};
    end
  endgenerate

  // Axis state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        mask_r[i]  <= 3'b000;
        miss_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < 2; i++) begin
        mask_r[i]  <= mask_nxt[i];
        miss_r[i]  <= miss_nxt[i];
        count_r[i] <= count_nxt[i];
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // Output payload, loaded with the state after the update.
  always_ff @(posedge clk) begin
    if (step) begin
      lr_count_r <= count16[0];
      ud_count_r <= count16[1];
      lr_bands_r <= mask_nxt[0];
      ud_bands_r <= mask_nxt[1];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_left_right_count = lr_count_r;
  assign out_up_down_count    = ud_count_r;
  assign out_left_right_bands = lr_bands_r;
  assign out_up_down_bands    = ud_bands_r;

endmodule

### rtl/grid_line_crossing_counter_top.sv
// Top level of the grid line crossing counter: configuration registers and
// the front end, queue and back end. Depends on glcc_pkg, glcc_front,
// glcc_queue and glcc_back.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_operation, in_rho, in_theta
//   out_     output     out_valid / out_ready  counts and band masks of both axes
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle is sustained while out_ready stays high: the front end
// classifies in the cycle of the transfer, and the back end updates the axis
// state and loads the output register together. An item passes the queue
// register and then the output register before out_valid shows its result.
// Reset is synchronous and active low; it clears the queue, the axis state and
// restores the register defaults. A stalled output fills the two-entry queue,
// after which in_ready drops.
module grid_line_crossing_counter_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [glcc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [glcc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic signed [14:0]                    in_rho,
  input  logic signed [14:0]                    in_theta,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [15:0]                    out_left_right_count,
  output logic signed [15:0]                    out_up_down_count,
  output logic [2:0]                            out_left_right_bands,
  output logic [2:0]                            out_up_down_bands
);
  import glcc_pkg::*;

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  q_full;
  logic  push_valid;
  item_t push_item;
  logic  pop_valid;
  item_t pop_item;
  logic  pop_ready;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_HORIZONTAL_CENTER: cfg_nxt.horizontal_center = cfg_wdata[9:0];
        REG_VERTICAL_CENTER:   cfg_nxt.vertical_center   = cfg_wdata[9:0];
        REG_INNER_BAND:        cfg_nxt.inner_band        = cfg_wdata[7:0];
        REG_OUTER_BAND:        cfg_nxt.outer_band        = cfg_wdata[7:0];
        REG_ANGLE_TOLERANCE:   cfg_nxt.angle_tolerance   = cfg_wdata[11:0];
        REG_MISS_LIMIT:        cfg_nxt.miss_limit        = cfg_wdata[7:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizontal_center <= RST_HORIZONTAL_CENTER;
      cfg_r.vertical_center   <= RST_VERTICAL_CENTER;
      cfg_r.inner_band        <= RST_INNER_BAND;
      cfg_r.outer_band        <= RST_OUTER_BAND;
      cfg_r.angle_tolerance   <= RST_ANGLE_TOLERANCE;
      cfg_r.miss_limit        <= RST_MISS_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  glcc_front u_front (
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_rho       (in_rho),
    .in_theta     (in_theta),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  glcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  glcc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .miss_limit           (cfg_r.miss_limit),
    .pop_valid            (pop_valid),
    .pop_item             (pop_item),
    .pop_ready            (pop_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_right_count (out_left_right_count),
    .out_up_down_count    (out_up_down_count),
    .out_left_right_bands (out_left_right_bands),
    .out_up_down_bands    (out_up_down_bands)
  );

endmodule
